[hw/rtl/gda_pkg.sv]
`timescale 1ns / 1ps
// gda_pkg: types, field layout, op codes and calendar tables for the
// gregorian date arithmetic core; no dependencies
package gda_pkg;

	// field widths
	localparam int W_YEAR  = 12;
	localparam int W_MONTH = 4;
	localparam int W_DAY   = 5;
	localparam int W_OFF   = 17;
	localparam int W_DIST  = 17;

	// internal year counter width, holds any year up to 9999
	localparam int YEAR_IW = 14;

	// input tdata layout, lowest bit first
	localparam int IN_YEAR_LO   = 0;
	localparam int IN_MONTH_LO  = IN_YEAR_LO + W_YEAR;
	localparam int IN_DAY_LO    = IN_MONTH_LO + W_MONTH;
	localparam int IN_OYEAR_LO  = IN_DAY_LO + W_DAY;
	localparam int IN_OMONTH_LO = IN_OYEAR_LO + W_YEAR;
	localparam int IN_ODAY_LO   = IN_OMONTH_LO + W_MONTH;
	localparam int IN_OFF_LO    = IN_ODAY_LO + W_DAY;
	localparam int IN_W         = IN_OFF_LO + W_OFF;
	localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;

	// output tdata layout
	localparam int OUT_W       = W_YEAR + W_MONTH + W_DAY + W_DIST + 2;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUB  = 2'd1,
		OP_DIFF = 2'd2,
		OP_CMP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_IN,
		ST_MONTHS,
		ST_EXEC,
		ST_WALK_OUT,
		ST_MONTH_OUT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic walk_in;
		logic months;
		logic exec;
		logic walk_out;
		logic month_out;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_in_done;
		logic walk_out_done;
		logic month_out_done;
		logic date_op;
	} stat_t;

	localparam logic [4:0] MONTH_LEN [0:12] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
		5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	// days in the months before a month, common year
	localparam logic [8:0] CUM_DAYS [0:12] = '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120,
		9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

	// leap rule from the year modulo 400
	function automatic logic leap_of(input logic [8:0] m400);
		return (m400[1:0] == 2'd0) && (m400 != 9'd100) && (m400 != 9'd200) &&
			(m400 != 9'd300);
	endfunction

	function automatic logic [8:0] m400_inc(input logic [8:0] m400);
		return (m400 == 9'd399) ? 9'd0 : m400 + 9'd1;
	endfunction

	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
		logic [4:0] r;
		r = 5'd0;
		if (m == 4'd2)
			r = leap ? 5'd29 : 5'd28;
		else if (m >= 4'd1 && m <= 4'd12)
			r = MONTH_LEN[m];
		return r;
	endfunction

	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] m);
		logic [8:0] r;
		r = 9'd0;
		if (m >= 4'd1 && m <= 4'd12)
			r = CUM_DAYS[m] + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
		return r;
	endfunction

endpackage

[hw/rtl/gregorian_date_arithmetic_core.sv]
`timescale 1ns / 1ps
// gregorian_date_arithmetic_core: top level of the date arithmetic core,
// joins gda_ctrl and gda_datapath; depends on gda_pkg
//
// One item at a time: an input transfer carries two dates, an op and a day
// count, and one result transfer follows. Dates are turned into day numbers
// counted from BASE_YEAR-01-01 by a walker that steps one year per cycle;
// for add and subtract the result day number is walked back, year by year
// and then month by month, into a date. The year walker dominates the run
// time. Invalid dates count as BASE_YEAR-01-01; add and subtract saturate
// at either end of the year range and raise clamped. A new item is taken
// while the previous result waits in the output register.
module gregorian_date_arithmetic_core import gda_pkg::*; #(
	parameter int BASE_YEAR = 1900,
	parameter int MAX_YEAR  = 2155
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// year[11:0], month[15:12], day[20:16], other_year[32:21],
	// other_month[36:33], other_day[41:37], day_offset[58:42], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// res_year[11:0], res_month[15:12], res_day[20:16], day_distance[37:21],
	// is_earlier[38], clamped[39]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	cmd_t             cmd;
	stat_t            stat;
	logic [OUT_W-1:0] out_data;

	// sequencer
	gda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	gda_datapath #(
		.BASE_YEAR (BASE_YEAR),
		.MAX_YEAR  (MAX_YEAR)
	) u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_tdata[IN_W-1:0]),
		.in_op    (s_tuser),
		.out_data (out_data)
	);

	assign m_tdata = OUT_TDATA_W'(out_data);

endmodule

[hw/rtl/gda_ctrl.sv]
`timescale 1ns / 1ps
// gda_ctrl: sequencer of the date core, issues datapath commands and owns
// the output valid flag; depends on gda_pkg
module gda_ctrl import gda_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   m_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid: set on load, cleared on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_WALK_IN;
				end
			end
			ST_WALK_IN: begin
				cmd.walk_in = 1'b1;
				if (stat.walk_in_done)
					state_d = ST_MONTHS;
			end
			ST_MONTHS: begin
				cmd.months = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.date_op ? ST_WALK_OUT : ST_DONE;
			end
			ST_WALK_OUT: begin
				cmd.walk_out = 1'b1;
				if (stat.walk_out_done)
					state_d = ST_MONTH_OUT;
			end
			ST_MONTH_OUT: begin
				cmd.month_out = 1'b1;
				if (stat.month_out_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/gda_datapath.sv]
`timescale 1ns / 1ps
// gda_datapath: year walker, day number adders, op unit and output register
// of the date core; depends on gda_pkg
module gda_datapath import gda_pkg::*; #(
	parameter int BASE_YEAR = 1900,
	parameter int MAX_YEAR  = 2155
) (
	input  logic                   clk,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [IN_W-1:0]        in_data,
	input  logic [1:0]             in_op,
	output logic [OUT_W-1:0]       out_data
);

	// day number of the last day of MAX_YEAR
	localparam int LB_BASE = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100 + (BASE_YEAR - 1) / 400;
	localparam int LB_TOP  = MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
	localparam int TOP     = (MAX_YEAR - BASE_YEAR + 1) * 365 + LB_TOP - LB_BASE - 1;
	localparam int DN_W    = $clog2(TOP + 2);
	localparam int SUM_W   = ((DN_W > W_OFF) ? DN_W : W_OFF) + 1;

	localparam logic [YEAR_IW-1:0] BASE_Y     = YEAR_IW'(BASE_YEAR);
	localparam logic [YEAR_IW-1:0] MAX_Y      = YEAR_IW'(MAX_YEAR);
	localparam logic [8:0]         BASE_M400  = 9'(BASE_YEAR % 400);
	localparam logic [SUM_W-1:0]   TOP_S      = SUM_W'(TOP);

	// captured item
	logic [1:0]         op_q;
	logic [W_YEAR-1:0]  ya_q, yb_q;
	logic [W_MONTH-1:0] ma_q, mb_q;
	logic [W_DAY-1:0]   da_q, db_q;
	logic [W_OFF-1:0]   off_q;

	// walker and working registers
	logic [YEAR_IW-1:0] yy_q;
	logic [8:0]         m400_q;
	logic [DN_W-1:0]    acc_q;
	logic [DN_W-1:0]    a_base_q, b_base_q;
	logic               a_leap_q, b_leap_q;
	logic               a_hit_q, b_hit_q;
	logic [DN_W-1:0]    na_q, nb_q;
	logic [DN_W-1:0]    n_q;
	logic [W_MONTH-1:0] mm_q;
	logic [W_DIST-1:0]  dist_q;
	logic               early_q, clamp_q;
	logic [OUT_W-1:0]   out_q;

	logic               lp;
	logic [8:0]         ylen;
	logic [YEAR_IW-1:0] ya_x, yb_x;
	logic               a_in, b_in, a_hit_now, b_hit_now, need_b;
	logic               a_ok, b_ok;
	logic [DN_W:0]      a_sum, b_sum;
	logic [DN_W-1:0]    a_num, b_num;
	logic [SUM_W-1:0]   a_ext, b_ext, off_ext, add_s, sub_s, diff_s;
	logic               add_over, sub_under;
	logic [DN_W-1:0]    n_next;
	logic [W_DIST-1:0]  dist_next;
	logic               early_next, clamp_next;
	logic [4:0]         md;
	logic               wo_done, mo_done;

	// leap flag and length of the walker's current year
	assign lp   = leap_of(m400_q);
	assign ylen = lp ? 9'd366 : 9'd365;

	// range and hit checks for the input years
	assign ya_x      = YEAR_IW'(ya_q);
	assign yb_x      = YEAR_IW'(yb_q);
	assign a_in      = (ya_x >= BASE_Y) && (ya_x <= MAX_Y);
	assign b_in      = (yb_x >= BASE_Y) && (yb_x <= MAX_Y);
	assign a_hit_now = (yy_q == ya_x);
	assign b_hit_now = (yy_q == yb_x);
	assign need_b    = (op_q == OP_DIFF) || (op_q == OP_CMP);

	// month and day checks, then day numbers of both dates
	assign a_ok  = a_hit_q && (ma_q >= 4'd1) && (ma_q <= 4'd12) && (da_q != 5'd0) &&
		(da_q <= month_days(a_leap_q, ma_q));
	assign b_ok  = b_hit_q && (mb_q >= 4'd1) && (mb_q <= 4'd12) && (db_q != 5'd0) &&
		(db_q <= month_days(b_leap_q, mb_q));
	assign a_sum = (DN_W+1)'(a_base_q) + (DN_W+1)'(cum_days(a_leap_q, ma_q)) +
		(DN_W+1)'(da_q) - (DN_W+1)'(1);
	assign b_sum = (DN_W+1)'(b_base_q) + (DN_W+1)'(cum_days(b_leap_q, mb_q)) +
		(DN_W+1)'(db_q) - (DN_W+1)'(1);
	assign a_num = a_ok ? a_sum[DN_W-1:0] : '0;
	assign b_num = b_ok ? b_sum[DN_W-1:0] : '0;

	// op unit
	assign a_ext     = SUM_W'(na_q);
	assign b_ext     = SUM_W'(nb_q);
	assign off_ext   = SUM_W'(off_q);
	assign add_s     = a_ext + off_ext;
	assign sub_s     = a_ext - off_ext;
	assign add_over  = add_s > TOP_S;
	assign sub_under = off_ext > a_ext;
	assign diff_s    = (a_ext > b_ext) ? (a_ext - b_ext) : (b_ext - a_ext);

	always_comb begin
		n_next     = '0;
		dist_next  = '0;
		early_next = 1'b0;
		clamp_next = 1'b0;
		unique case (op_t'(op_q))
			OP_ADD: begin
				n_next     = add_over ? TOP_S[DN_W-1:0] : add_s[DN_W-1:0];
				clamp_next = add_over;
			end
			OP_SUB: begin
				n_next     = sub_under ? '0 : sub_s[DN_W-1:0];
				clamp_next = sub_under;
			end
			OP_DIFF: begin
				dist_next = diff_s[W_DIST-1:0];
			end
			OP_CMP: begin
				early_next = na_q < nb_q;
			end
			default: begin
				n_next = '0;
			end
		endcase
	end

	// conversion back to a date
	assign md      = month_days(lp, mm_q);
	assign wo_done = (yy_q >= MAX_Y) || (n_q < DN_W'(ylen));
	assign mo_done = (mm_q == 4'd12) || (n_q < DN_W'(md));

	always_comb begin
		stat.walk_in_done   = (!a_in || a_hit_q || a_hit_now) &&
			(!need_b || !b_in || b_hit_q || b_hit_now);
		stat.walk_out_done  = wo_done;
		stat.month_out_done = mo_done;
		stat.date_op        = (op_q == OP_ADD) || (op_q == OP_SUB);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= in_op;
			ya_q    <= in_data[IN_YEAR_LO +: W_YEAR];
			ma_q    <= in_data[IN_MONTH_LO +: W_MONTH];
			da_q    <= in_data[IN_DAY_LO +: W_DAY];
			yb_q    <= in_data[IN_OYEAR_LO +: W_YEAR];
			mb_q    <= in_data[IN_OMONTH_LO +: W_MONTH];
			db_q    <= in_data[IN_ODAY_LO +: W_DAY];
			off_q   <= in_data[IN_OFF_LO +: W_OFF];
			yy_q    <= BASE_Y;
			m400_q  <= BASE_M400;
			acc_q   <= '0;
			a_hit_q <= 1'b0;
			b_hit_q <= 1'b0;
		end
		// year walk up to the input years
		if (cmd.walk_in) begin
			if (a_hit_now) begin
				a_hit_q  <= 1'b1;
				a_base_q <= acc_q;
				a_leap_q <= lp;
			end
			if (b_hit_now) begin
				b_hit_q  <= 1'b1;
				b_base_q <= acc_q;
				b_leap_q <= lp;
			end
			if (!stat.walk_in_done) begin
				yy_q   <= yy_q + YEAR_IW'(1);
				m400_q <= m400_inc(m400_q);
				acc_q  <= acc_q + DN_W'(ylen);
			end
		end
		if (cmd.months) begin
			na_q <= a_num;
			nb_q <= b_num;
		end
		// op result, walker rewound for the way back
		if (cmd.exec) begin
			n_q     <= n_next;
			dist_q  <= dist_next;
			early_q <= early_next;
			clamp_q <= clamp_next;
			yy_q    <= BASE_Y;
			m400_q  <= BASE_M400;
			mm_q    <= 4'd1;
		end
		if (cmd.walk_out && !wo_done) begin
			n_q    <= n_q - DN_W'(ylen);
			yy_q   <= yy_q + YEAR_IW'(1);
			m400_q <= m400_inc(m400_q);
		end
		if (cmd.month_out && !mo_done) begin
			n_q  <= n_q - DN_W'(md);
			mm_q <= mm_q + 4'd1;
		end
		if (cmd.load_out) begin
			out_q <= {clamp_q, early_q, dist_q, n_q[W_DAY-1:0] + 5'd1, mm_q,
				yy_q[W_YEAR-1:0]};
		end
	end

	assign out_data = out_q;

endmodule

[hw/rtl/gda_checker.sv]
`timescale 1ns / 1ps
// gda_checker: port-level checks of the date core, bound to the top level;
// depends on gda_pkg
module gda_checker import gda_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: no back-to-back input transfers
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// result month and day are real calendar values
	a_res_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12) &&
			(m_tdata[20:16] != 5'd0))
		else $error("bad result date");

	// clamping only on date ops, which carry no distance or compare flag
	a_clamp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39] |-> (m_tdata[38:21] == '0))
		else $error("clamped with distance or compare set");

	// a distance and an earlier flag never come together
	a_op_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38] |-> (m_tdata[37:21] == '0))
		else $error("compare result with distance set");

endmodule

bind gregorian_date_arithmetic_core gda_checker u_gda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
